// ===== sv/ddq_pkg.sv =====
// ----------------------------------------------------------------------------
// ddq_pkg: shared types and constants of the date deque
// Entry layout, command and status codes, per-cell control bundle.
// ----------------------------------------------------------------------------
package ddq_pkg;

	// Number of cells in the chain
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths of the request and response
	localparam int CMD_W   = 3;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int YEAR_W  = 16;
	localparam int POS_W   = 4;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 5;

	typedef struct packed {
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [YEAR_W-1:0]  year;
	} date_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT  = 3'd0,
		CMD_PUSH_BACK   = 3'd1,
		CMD_REMOVE_FRONT = 3'd2,
		CMD_REMOVE_BACK = 3'd3,
		CMD_SEARCH      = 3'd4,
		CMD_READ        = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic  shift_up;    // push front: every cell takes its lower neighbor
		logic  shift_down;  // remove front: every cell takes its upper neighbor
		logic  load_tail;   // push back: the tail cell takes the key
		date_t key;
	} cell_ctl_t;

endpackage

// ===== sv/ddq_req_if.sv =====
// ----------------------------------------------------------------------------
// ddq_req_if: command channel of the date deque
// Valid/ready handshake with command, date and position payload.
// ----------------------------------------------------------------------------
interface ddq_req_if;
	logic                        valid;
	logic                        ready;
	logic [ddq_pkg::CMD_W-1:0]   cmd;
	logic [ddq_pkg::MONTH_W-1:0] month;
	logic [ddq_pkg::DAY_W-1:0]   day;
	logic [ddq_pkg::YEAR_W-1:0]  year;
	logic [ddq_pkg::POS_W-1:0]   position;

	modport source (output valid, cmd, month, day, year, position, input ready);
	modport sink (input valid, cmd, month, day, year, position, output ready);
endinterface

// ===== sv/ddq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ddq_rsp_if: response channel of the date deque
// Valid/ready handshake with status, match position, date and count payload.
// ----------------------------------------------------------------------------
interface ddq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ddq_pkg::STAT_W-1:0]  status;
	logic [ddq_pkg::POS_W-1:0]   found_position;
	logic [ddq_pkg::MONTH_W-1:0] month_out;
	logic [ddq_pkg::DAY_W-1:0]   day_out;
	logic [ddq_pkg::YEAR_W-1:0]  year_out;
	logic [ddq_pkg::COUNT_W-1:0] count;

	modport source (output valid, status, found_position, month_out, day_out, year_out,
		count, input ready);
	modport sink (input valid, status, found_position, month_out, day_out, year_out,
		count, output ready);
endinterface

// ===== sv/ddq_cell.sv =====
// ----------------------------------------------------------------------------
// ddq_cell: one position of the deque
// Holds one date, shifts with its neighbors, compares against the search key
// and forwards the first-match chain.
// ----------------------------------------------------------------------------
module ddq_cell (
	input  logic               clk,
	input  ddq_pkg::cell_ctl_t ctl,
	input  logic               occupied,
	input  logic               tail,
	input  ddq_pkg::date_t     from_lo,
	input  ddq_pkg::date_t     from_hi,
	input  logic               hit_in,
	output ddq_pkg::date_t     date,
	output logic               hit_out,
	output logic               first_hit
);
	ddq_pkg::date_t date_q;
	logic           eq;

	// Entry storage; contents are only meaningful while occupied
	always_ff @(posedge clk) begin
		if (ctl.shift_up) begin
			date_q <= from_lo;
		end else if (ctl.shift_down) begin
			date_q <= from_hi;
		end else if (ctl.load_tail && tail) begin
			date_q <= ctl.key;
		end
	end

	// Compare and first-match chain
	assign eq        = occupied && (date_q == ctl.key);
	assign first_hit = eq && !hit_in;
	assign hit_out   = hit_in || eq;
	assign date      = date_q;

endmodule

// ===== sv/date_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// date_deque_with_search: bounded double-ended queue of dates with search
// Row of DEPTH cells, position 0 at the front, plus a registered response.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: push front, push back, remove front, remove
//   back, search for the first equal date, or read at a position from the
//   front. Each request gives exactly one response on rsp with a status,
//   the match position, the date read or matched, and the count held after
//   the request.
//   Each response is registered: a request accepted at a clock edge has its
//   response valid in the following cycle. One request per cycle is sustained
//   while rsp.ready is high: every cell shifts, loads or compares in the same
//   cycle, and the search result ripples down the cell chain to a priority pick.
//   While a response waits, req.ready stays high only if rsp.ready takes it
//   in that cycle; a stalled response holds and no request is taken.
//   Reset empties the queue (count zero); cell contents are not cleared
//   and are never shown until written.
// ----------------------------------------------------------------------------
module date_deque_with_search (
	input logic       clk,
	input logic       arst_n,
	ddq_req_if.sink   req,
	ddq_rsp_if.source rsp
);
	localparam int DEPTH = ddq_pkg::DEPTH;
	localparam int IDX_W = ddq_pkg::IDX_W;
	localparam int CNT_W = ddq_pkg::CNT_W;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	logic                rsp_valid_q;
	ddq_pkg::status_t    status_q;
	logic [ddq_pkg::POS_W-1:0] fpos_q;
	ddq_pkg::date_t      hit_q;

	logic                accept;
	logic                full;
	logic                empty;
	ddq_pkg::cmd_t       cmd;
	ddq_pkg::date_t      key;
	ddq_pkg::cell_ctl_t  ctl;
	ddq_pkg::status_t    status_nxt;
	logic [IDX_W-1:0]    fpos;
	ddq_pkg::date_t      hit_nxt;

	ddq_pkg::date_t      cell_date [DEPTH];
	logic [DEPTH:0]      hit_chain;
	logic [DEPTH-1:0]    first_hit;
	logic [DEPTH-1:0]    occupied;
	logic [DEPTH-1:0]    tail;

	// Handshake
	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign cmd       = ddq_pkg::cmd_t'(req.cmd);
	assign key       = '{month: req.month, day: req.day, year: req.year};

	// Cell control
	always_comb begin
		ctl            = '0;
		ctl.key        = key;
		ctl.shift_up   = accept && (cmd == ddq_pkg::CMD_PUSH_FRONT) && !full;
		ctl.shift_down = accept && (cmd == ddq_pkg::CMD_REMOVE_FRONT) && !empty;
		ctl.load_tail  = accept && (cmd == ddq_pkg::CMD_PUSH_BACK) && !full;
	end

	// Cell chain
	assign hit_chain[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occupied[i] = (CNT_W'(i) < count_q);
		assign tail[i]     = (CNT_W'(i) == count_q);

		ddq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occupied[i]),
			.tail      (tail[i]),
			.from_lo   ((i == 0) ? key : cell_date[(i == 0) ? 0 : i - 1]),
			.from_hi   (cell_date[(i == DEPTH - 1) ? i : i + 1]),
			.hit_in    (hit_chain[i]),
			.date      (cell_date[i]),
			.hit_out   (hit_chain[i+1]),
			.first_hit (first_hit[i])
		);
	end

	// Encode the one-hot first match
	always_comb begin
		fpos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_hit[i]) begin
				fpos = fpos | IDX_W'(i);
			end
		end
	end

	// Response and next count
	always_comb begin
		status_nxt = ddq_pkg::ST_OK;
		hit_nxt    = '0;
		count_nxt  = count_q;
		case (cmd)
			ddq_pkg::CMD_PUSH_FRONT, ddq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_nxt = ddq_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			ddq_pkg::CMD_REMOVE_FRONT, ddq_pkg::CMD_REMOVE_BACK: begin
				if (empty) begin
					status_nxt = ddq_pkg::ST_EMPTY;
				end else begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			ddq_pkg::CMD_SEARCH: begin
				if (hit_chain[DEPTH]) begin
					hit_nxt = key;
				end else begin
					status_nxt = ddq_pkg::ST_NOT_FOUND;
				end
			end
			ddq_pkg::CMD_READ: begin
				if (empty) begin
					status_nxt = ddq_pkg::ST_EMPTY;
				end else if (int'(req.position) >= int'(count_q)) begin
					status_nxt = ddq_pkg::ST_RANGE;
				end else begin
					hit_nxt = cell_date[IDX_W'(req.position)];
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			hit_q    <= hit_nxt;
			fpos_q   <= (cmd == ddq_pkg::CMD_SEARCH && hit_chain[DEPTH]) ?
				ddq_pkg::POS_W'(fpos) : '0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.found_position = fpos_q;
	assign rsp.month_out      = hit_q.month;
	assign rsp.day_out        = hit_q.day;
	assign rsp.year_out       = hit_q.year;
	assign rsp.count          = ddq_pkg::COUNT_W'(count_q);

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count above depth");

	a_single_first: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_hit))
		else $error("more than one first match");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.shift_up || ctl.load_tail) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not grow count");

	a_empty_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && empty && (cmd == ddq_pkg::CMD_REMOVE_FRONT ||
		cmd == ddq_pkg::CMD_REMOVE_BACK)) |=> (count_q == '0 &&
		status_q == ddq_pkg::ST_EMPTY))
		else $error("remove on empty changed count");

endmodule
